FILE: rtl/core/lcd_multiplex_scan_driver_core_defines.svh
// Assertion macros shared by the LCD scan driver RTL.
`ifndef LCD_MULTIPLEX_SCAN_DRIVER_CORE_DEFINES_SVH
`define LCD_MULTIPLEX_SCAN_DRIVER_CORE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define LMSD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies a result in the next cycle.
`define LMSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lmsd_pkg.sv
// Types, constants and segment encoding functions for the LCD scan driver.
package lmsd_pkg;

   localparam logic [2:0] MODE_TEMP     = 3'd0;
   localparam logic [2:0] MODE_SETPOINT = 3'd1;
   localparam logic [2:0] MODE_CO       = 3'd2;
   localparam logic [2:0] MODE_PAIRING  = 3'd3;
   localparam logic [2:0] MODE_HOLD     = 3'd4;

   localparam logic [1:0] LAST_COMMON = 2'd3;

   localparam logic [6:0] SEG_A = 7'h01;
   localparam logic [6:0] SEG_B = 7'h02;
   localparam logic [6:0] SEG_C = 7'h04;
   localparam logic [6:0] SEG_D = 7'h08;
   localparam logic [6:0] SEG_E = 7'h10;
   localparam logic [6:0] SEG_F = 7'h20;
   localparam logic [6:0] SEG_G = 7'h40;

   typedef struct packed {
      logic [2:0] display_mode;
      logic       blink_on;
      logic [6:0] setpoint;
      logic [9:0] temp_tenths;
      logic       resync;
   } req_type;

   typedef struct packed {
      logic [3:0] com_enable;
      logic [3:0] com_level;
      logic [3:0] seg_enable;
      logic [3:0] seg_level;
      logic [1:0] active_common;
      logic       drive_phase;
   } rsp_type;

   // Scan position handed from the scan counter to the pipeline.
   typedef struct packed {
      logic [1:0] common;
      logic       phase;
   } scan_type;

   // Quotient by ten for values up to 1028: multiply by 205/2048.
   function automatic logic [6:0] div10(input logic [10:0] x);
      logic [18:0] prod;
      prod = {8'd0, x} * 19'd205;
      return prod[17:11];
   endfunction

   // Seven-segment mask of one digit; codes above nine are blank.
   function automatic logic [6:0] digit_mask(input logic [6:0] d);
      logic [6:0] m;
      unique case (d)
         7'd0:    m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         7'd1:    m = SEG_B | SEG_C;
         7'd2:    m = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
         7'd3:    m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
         7'd4:    m = SEG_B | SEG_C | SEG_F | SEG_G;
         7'd5:    m = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
         7'd6:    m = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         7'd7:    m = SEG_A | SEG_B | SEG_C;
         7'd8:    m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         7'd9:    m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         default: m = 7'h00;
      endcase
      return m;
   endfunction

   // Map a digit pair onto the four segment pins of one common.
   function automatic logic [3:0] pair_pins(input logic [1:0] com, input logic [6:0] l,
                                            input logic [6:0] r, input logic degree);
      logic [3:0] p;
      unique case (com)
         2'd0:    p = {1'b0, |(r & SEG_A), degree, |(l & SEG_A)};
         2'd1:    p = {|(r & SEG_B), |(r & SEG_F), |(l & SEG_B), |(l & SEG_F)};
         2'd2:    p = {|(r & SEG_G), |(r & SEG_E), |(l & SEG_G), |(l & SEG_E)};
         default: p = {|(r & SEG_C), |(r & SEG_D), |(l & SEG_C), |(l & SEG_D)};
      endcase
      return p;
   endfunction

   // Fixed "P" pattern per common.
   function automatic logic [3:0] pat_p(input logic [1:0] com);
      logic [3:0] p;
      unique case (com)
         2'd0:    p = 4'h1;
         2'd1:    p = 4'h3;
         2'd2:    p = 4'h3;
         default: p = 4'h0;
      endcase
      return p;
   endfunction

   // Fixed "CO" pattern per common.
   function automatic logic [3:0] pat_co(input logic [1:0] com);
      return com[0] ? 4'hD : 4'h5;
   endfunction

endpackage

FILE: rtl/core/lmsd_scan_ctrl.sv
// Scan position counter: active common and drive phase.
module lmsd_scan_ctrl
   import lmsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     resync,
   output scan_type scan
);

   logic [1:0] common_ff, common_in;
   logic       phase_ff, phase_in;

   // Apply resync before this transaction, then step to the next common.
   always_comb begin
      scan.common = resync ? 2'd0 : common_ff;
      scan.phase  = resync ? 1'b0 : phase_ff;
      common_in   = common_ff;
      phase_in    = phase_ff;
      if (advance) begin
         if (scan.common == LAST_COMMON) begin
            common_in = 2'd0;
            phase_in  = ~scan.phase;
         end else begin
            common_in = scan.common + 2'd1;
            phase_in  = scan.phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         common_ff <= 2'd0;
         phase_ff  <= 1'b0;
      end else begin
         common_ff <= common_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

FILE: rtl/core/lmsd_seg_encode.sv
// Segment pattern and pin drive levels for one scan tick.
module lmsd_seg_encode
   import lmsd_pkg::*;
(
   input  req_type  item,
   input  scan_type scan,
   output rsp_type  result
);

   logic [10:0] temp_round;
   logic [6:0]  temp_whole;
   logic [6:0]  temp_tens;
   logic [6:0]  temp_tens_x10;
   logic [6:0]  temp_units;
   logic [6:0]  sp_tens;
   logic [6:0]  sp_tens_x10;
   logic [6:0]  sp_units;
   logic [3:0]  seg;
   logic [3:0]  com_en;

   // Split temperature and setpoint into decimal digits.
   always_comb begin
      temp_round    = {1'b0, item.temp_tenths} + 11'd5;
      temp_whole    = div10(temp_round);
      temp_tens     = div10({4'd0, temp_whole});
      temp_tens_x10 = temp_tens * 7'd10;
      temp_units    = temp_whole - temp_tens_x10;
      sp_tens       = div10({4'd0, item.setpoint});
      sp_tens_x10   = sp_tens * 7'd10;
      sp_units      = item.setpoint - sp_tens_x10;
   end

   // Select the segment pins for the display mode.
   always_comb begin
      priority case (item.display_mode)
         MODE_PAIRING:  seg = pat_p(scan.common);
         MODE_CO:       seg = item.blink_on ? pat_co(scan.common) : 4'h0;
         MODE_HOLD:     seg = pair_pins(scan.common, digit_mask(7'd9), digit_mask(7'd9),
                                        1'b0);
         MODE_SETPOINT: seg = item.blink_on ?
                              pair_pins(scan.common, digit_mask(sp_tens),
                                        digit_mask(sp_units), 1'b0) : 4'h0;
         default:       seg = pair_pins(scan.common, digit_mask(temp_tens),
                                        digit_mask(temp_units), 1'b1);
      endcase
   end

   // Drive levels: common at the phase, lit segments at its inverse.
   always_comb begin
      com_en               = 4'b0001 << scan.common;
      result.com_enable    = com_en;
      result.com_level     = scan.phase ? com_en : 4'h0;
      result.seg_enable    = seg;
      result.seg_level     = scan.phase ? 4'h0 : seg;
      result.active_common = scan.common;
      result.drive_phase   = scan.phase;
   end

endmodule

FILE: rtl/core/lcd_multiplex_scan_driver_core.sv
// Top level of the multiplexed four-common LCD scan driver.
// Registered path from request transaction to response valid: input register, then result register.
// Throughput: one transaction per cycle; a response stall holds off requests only when both stages are full.
// The scan counter advances at request acceptance, so a stall never reorders commons.
// Reset (synchronous, active high) clears both stage valids, common index and phase.
`include "lcd_multiplex_scan_driver_core_defines.svh"
module lcd_multiplex_scan_driver_core
   import lmsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     req_accept;
   logic     s1_move;
   scan_type scan_now;
   rsp_type  s1_result;

   logic     s1_valid_ff, s1_valid_in;
   req_type  s1_item_ff;
   scan_type s1_scan_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;

   // Handshake: each stage moves when the stage after it is free or draining.
   assign s1_move    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   lmsd_scan_ctrl u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .resync  (req_data.resync),
      .scan    (scan_now)
   );

   lmsd_seg_encode u_encode (
      .item   (s1_item_ff),
      .scan   (s1_scan_ff),
      .result (s1_result)
   );

   // Track stage occupancy.
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the item with its scan position, then the finished result.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_data;
         s1_scan_ff <= scan_now;
      end
      if (s1_move) begin
         out_data_ff <= s1_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `LMSD_ASSERT_ALWAYS(a_com_onehot, clock, reset,
      !rsp_valid || $onehot(rsp_data.com_enable), "com_enable not one-hot")
   `LMSD_ASSERT_ALWAYS(a_seg_phase, clock, reset,
      !rsp_valid || (rsp_data.drive_phase ? (rsp_data.seg_level == 4'h0)
                                          : (rsp_data.seg_level == rsp_data.seg_enable)),
      "segment level does not follow drive phase")
   `LMSD_ASSERT_NEXT(a_resync_zero, clock, reset,
      req_accept && req_data.resync,
      s1_valid_ff && (s1_scan_ff.common == 2'd0) && !s1_scan_ff.phase,
      "resync did not clear scan position")
   `LMSD_ASSERT_ALWAYS(a_stall_cause, clock, reset,
      !req_stall || (s1_valid_ff && out_valid_ff && rsp_stall),
      "request stalled without a full pipeline")

endmodule

FILE: sim/lcd_multiplex_scan_driver_core_test.sv
// Self-checking testbench for the four-common LCD scan driver core.
module lcd_multiplex_scan_driver_core_test
   import lmsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_SCANS = 1800;
   localparam int HOLD_CYCLES  = 200;
   localparam int HOLD_AFTER   = 500;
   localparam int DRAIN_CYCLES = 6;

   // Spare mode codes above hold; the block treats them as temperature.
   localparam logic [2:0] MODE_SPARE_5 = MODE_HOLD + 3'd1;
   localparam logic [2:0] MODE_SPARE_6 = MODE_HOLD + 3'd2;
   localparam logic [2:0] MODE_SPARE_7 = MODE_HOLD + 3'd3;

   typedef struct {
      req_type req;
      logic    fixed_result;
      rsp_type rsp;
   } scan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Scan position tracked by the predictor.
   logic [1:0] model_common;
   logic       model_phase;

   rsp_type      expected_scans[$];
   rsp_type      fixed_scans[$];
   logic         fixed_flags[$];
   scan_row_type scan_table[$];
   int           error_count = 0;
   int           delivered = 0;
   logic         long_hold = 1'b0;

   lcd_multiplex_scan_driver_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Segment masks of the decimal digits; anything above nine is dark.
   function automatic logic [6:0] digit_segments(input int unsigned d);
      logic [6:0] m;
      case (d)
         0: m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         1: m = SEG_B | SEG_C;
         2: m = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
         3: m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
         4: m = SEG_B | SEG_C | SEG_F | SEG_G;
         5: m = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
         6: m = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         7: m = SEG_A | SEG_B | SEG_C;
         8: m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         9: m = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         default: m = '0;
      endcase
      return m;
   endfunction

   // Route the lit segments of a digit pair onto the pins of one common.
   function automatic logic [3:0] digit_pins(input logic [1:0] com, input logic [6:0] lt,
                                             input logic [6:0] rt, input logic degree);
      logic [3:0] p;
      case (com)
         2'd0: p = {1'b0, (rt & SEG_A) != 0, degree, (lt & SEG_A) != 0};
         2'd1: p = {(rt & SEG_B) != 0, (rt & SEG_F) != 0, (lt & SEG_B) != 0, (lt & SEG_F) != 0};
         2'd2: p = {(rt & SEG_G) != 0, (rt & SEG_E) != 0, (lt & SEG_G) != 0, (lt & SEG_E) != 0};
         default:
            p = {(rt & SEG_C) != 0, (rt & SEG_D) != 0, (lt & SEG_C) != 0, (lt & SEG_D) != 0};
      endcase
      return p;
   endfunction

   // Compute the drive of one scan tick and advance the scan position.
   function automatic rsp_type predict_scan(input req_type r);
      rsp_type     o;
      logic [3:0]  pins;
      int unsigned whole;
      logic [3:0]  letter_p [4];
      logic [3:0]  letter_co [4];
      letter_p  = '{4'h1, 4'h3, 4'h3, 4'h0};
      letter_co = '{4'h5, 4'hD, 4'h5, 4'hD};
      if (r.resync) begin
         model_common = '0;
         model_phase  = 1'b0;
      end
      case (r.display_mode)
         MODE_PAIRING: pins = letter_p[model_common];
         MODE_CO:      pins = r.blink_on ? letter_co[model_common] : 4'h0;
         MODE_HOLD:
            pins = digit_pins(model_common, digit_segments(9), digit_segments(9), 1'b0);
         MODE_SETPOINT:
            pins = r.blink_on ? digit_pins(model_common, digit_segments(r.setpoint / 10),
                                           digit_segments(r.setpoint % 10), 1'b0) : 4'h0;
         default: begin
            whole = (r.temp_tenths + 5) / 10;
            pins  = digit_pins(model_common, digit_segments(whole / 10),
                               digit_segments(whole % 10), 1'b1);
         end
      endcase
      o.com_enable    = 4'b0001 << model_common;
      o.com_level     = model_phase ? o.com_enable : 4'h0;
      o.seg_enable    = pins;
      o.seg_level     = model_phase ? 4'h0 : pins;
      o.active_common = model_common;
      o.drive_phase   = model_phase;
      if (model_common == LAST_COMMON) begin
         model_common = '0;
         model_phase  = ~model_phase;
      end else begin
         model_common = model_common + 2'd1;
      end
      return o;
   endfunction

   function automatic req_type make_scan(input logic [2:0] mode, input logic blink,
                                         input logic [6:0] sp, input logic [9:0] tt,
                                         input logic rs);
      req_type r;
      r.display_mode = mode;
      r.blink_on     = blink;
      r.setpoint     = sp;
      r.temp_tenths  = tt;
      r.resync       = rs;
      return r;
   endfunction

   function automatic rsp_type make_drive(input logic [3:0] ce, input logic [3:0] cl,
                                          input logic [3:0] se, input logic [3:0] sl,
                                          input logic [1:0] com, input logic ph);
      rsp_type o;
      o.com_enable    = ce;
      o.com_level     = cl;
      o.seg_enable    = se;
      o.seg_level     = sl;
      o.active_common = com;
      o.drive_phase   = ph;
      return o;
   endfunction

   task automatic add_row(input req_type r, input logic fixed, input rsp_type o);
      scan_row_type row;
      row.req          = r;
      row.fixed_result = fixed;
      row.rsp          = o;
      scan_table.push_back(row);
   endtask

   // Hold valid and payload until the transaction is taken.
   task automatic offer_scan(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic req_type random_scan();
      logic [2:0] mode;
      if ($urandom_range(0, 9) == 0) mode = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      else mode = 3'($urandom_range(MODE_TEMP, MODE_HOLD));
      return make_scan(mode, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                       10'($urandom_range(0, 1023)), $urandom_range(0, 15) == 0);
   endfunction

   // Record accepted requests: predict, or take the typed-in drive.
   always @(posedge clock) begin
      rsp_type o;
      if (!reset && req_valid && !req_stall) begin
         o = predict_scan(req_data);
         if (fixed_flags.size() != 0) begin
            if (fixed_flags.pop_front()) o = fixed_scans.pop_front();
            else void'(fixed_scans.pop_front());
         end
         expected_scans.push_back(o);
      end
   end

   // Compare each delivered response with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         delivered <= delivered + 1;
         if (expected_scans.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count++;
         end else begin
            e = expected_scans.pop_front();
            if (rsp_data.com_enable !== e.com_enable) begin
               $error("com_enable expected %h actual %h", e.com_enable, rsp_data.com_enable);
               error_count++;
            end
            if (rsp_data.com_level !== e.com_level) begin
               $error("com_level expected %h actual %h", e.com_level, rsp_data.com_level);
               error_count++;
            end
            if (rsp_data.seg_enable !== e.seg_enable) begin
               $error("seg_enable expected %h actual %h", e.seg_enable, rsp_data.seg_enable);
               error_count++;
            end
            if (rsp_data.seg_level !== e.seg_level) begin
               $error("seg_level expected %h actual %h", e.seg_level, rsp_data.seg_level);
               error_count++;
            end
            if (rsp_data.active_common !== e.active_common) begin
               $error("active_common expected %0d actual %0d", e.active_common,
                      rsp_data.active_common);
               error_count++;
            end
            if (rsp_data.drive_phase !== e.drive_phase) begin
               $error("drive_phase expected %0d actual %0d", e.drive_phase,
                      rsp_data.drive_phase);
               error_count++;
            end
         end
      end
   end

   // Stall the response side in stretches of its own, with one long hold-off.
   initial begin
      int kind;
      int span;
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && delivered >= HOLD_AFTER) begin
            held = 1;
            long_hold = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            kind = $urandom_range(0, 2);
            span = $urandom_range(1, 40);
            repeat (span) begin
               case (kind)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= $urandom_range(0, 4) != 0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Give up if the run hangs.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   // Drive reset, the directed table, then random scans in bursts.
   initial begin
      int burst;
      int gap;
      int n;
      scan_row_type row;

      add_row(make_scan(MODE_HOLD, 1'b0, 7'd0, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h5, 4'h5, 2'd0, 1'b0));
      repeat (3) add_row(make_scan(MODE_HOLD, 1'b1, 7'd99, 10'd1023, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_TEMP, 1'b0, 7'd0, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h7, 4'h7, 2'd0, 1'b0));
      // tens digit of 102 is dark
      add_row(make_scan(MODE_TEMP, 1'b1, 7'd127, 10'd1023, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h6, 4'h6, 2'd0, 1'b0));
      add_row(make_scan(MODE_TEMP, 1'b0, 7'd0, 10'd994, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_TEMP, 1'b0, 7'd0, 10'd995, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_TEMP, 1'b1, 7'd0, 10'd999, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_TEMP, 1'b1, 7'd0, 10'd1023, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_PAIRING, 1'b0, 7'd0, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h1, 4'h1, 2'd0, 1'b0));
      repeat (3) add_row(make_scan(MODE_PAIRING, 1'b0, 7'd127, 10'd1023, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_CO, 1'b1, 7'd0, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h5, 4'h5, 2'd0, 1'b0));
      add_row(make_scan(MODE_CO, 1'b0, 7'd0, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h0, 4'h0, 2'd0, 1'b0));
      add_row(make_scan(MODE_SETPOINT, 1'b0, 7'd99, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h0, 4'h0, 2'd0, 1'b0));
      // setpoint 127: tens dark, units seven shows only its top bar on common 0
      add_row(make_scan(MODE_SETPOINT, 1'b1, 7'd127, 10'd0, 1'b1), 1'b1,
              make_drive(4'h1, 4'h0, 4'h4, 4'h4, 2'd0, 1'b0));
      add_row(make_scan(MODE_SETPOINT, 1'b1, 7'd0, 10'd0, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_SETPOINT, 1'b1, 7'd99, 10'd0, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_SETPOINT, 1'b1, 7'd88, 10'd0, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_SPARE_5, 1'b0, 7'd0, 10'd880, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_SPARE_6, 1'b1, 7'd0, 10'd5, 1'b0), 1'b0, '0);
      add_row(make_scan(MODE_SPARE_7, 1'b0, 7'd0, 10'd1000, 1'b0), 1'b0, '0);

      model_common = '0;
      model_phase  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table back to back
      foreach (scan_table[i]) begin
         row = scan_table[i];
         fixed_flags.push_back(row.fixed_result);
         fixed_scans.push_back(row.rsp);
         offer_scan(row.req);
      end

      // random scans: bursts with gaps, no gaps during the long hold-off
      burst = $urandom_range(1, 30);
      for (n = 0; n < RANDOM_SCANS; n++) begin
         offer_scan(random_scan());
         burst--;
         if (burst <= 0) begin
            burst = $urandom_range(1, 30);
            gap   = $urandom_range(0, 8);
            if (gap != 0 && !long_hold) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      // drain
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lmsd_pkg.sv
rtl/core/lmsd_scan_ctrl.sv
rtl/core/lmsd_seg_encode.sv
rtl/core/lcd_multiplex_scan_driver_core.sv
sim/lcd_multiplex_scan_driver_core_test.sv
